FILE: rtl/sm4_pkg.sv
// Package: SM4 constants, types and round functions.
package sm4_pkg;

    localparam int ROUNDS_DEF = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd4;

    localparam logic MODE_ECB = 1'b0;
    localparam logic MODE_CTR = 1'b1;

    localparam logic [127:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_CIPHER,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic key_load;   // start key expansion from key registers
        logic key_step;   // one key round, write round key
        logic blk_load;   // capture input item, load cipher state
        logic blk_step;   // one cipher round
        logic out_load;   // form result into output register
    } t_cmd;

    // input transfer payload
    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  valid_bytes;
        logic        message_start;
    } t_blk_in;

    // result transfer payload
    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } t_blk_out;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] v);
        tau = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    // CK word for key round i: byte j = (4i+j)*7 mod 256
    function automatic logic [31:0] ck_word(input logic [7:0] i);
        logic [7:0] b0;
        b0 = 8'((i << 2) * 7);
        ck_word = {b0, 8'(b0 + 8'd7), 8'(b0 + 8'd14), 8'(b0 + 8'd21)};
    endfunction

    // mask keeping the first n bytes (n 0..8) of a big-endian word
    function automatic logic [63:0] lead_mask(input logic [4:0] n);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            if (5'(k) < n) begin
                m[63-8*k -: 8] = 8'hff;
            end
        end
        lead_mask = m;
    endfunction

endpackage

FILE: rtl/sm4_stream_if.sv
// Valid/ready stream interface.
interface sm4_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sm4_block_cipher_ecb_ctr_unit.sv
// Top level: SM4 ECB/CTR encryption unit.
// One 128-bit block per transfer: an item is captured, run through the rounds
// of one shared round unit and its result formed in the output register before
// the next item is taken. A write to either key register triggers a key
// expansion (load step, key rounds) into the round key RAM before the next
// item is taken. The user must write configuration only while idle; the unit
// does not enforce it. Results wait in an output register until transferred.
module sm4_block_cipher_ecb_ctr_unit import sm4_pkg::*; #(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sm4_stream_if.sink            s_in,
    sm4_stream_if.source          m_out
);
    logic [63:0] r_key_high, r_key_low, r_nonce_high, r_nonce_low;
    logic        r_mode;
    logic        key_wr;
    t_cmd        cmd;
    logic [$clog2(ROUNDS)-1:0] round;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_nonce_high <= '0;
            r_nonce_low  <= '0;
            r_mode       <= MODE_ECB;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                REG_KEY_LOW:    r_key_low    <= i_cfg_data;
                REG_NONCE_HIGH: r_nonce_high <= i_cfg_data;
                REG_NONCE_LOW:  r_nonce_low  <= i_cfg_data;
                REG_MODE:       r_mode       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign key_wr = i_cfg_we && (i_cfg_idx == REG_KEY_HIGH || i_cfg_idx == REG_KEY_LOW);

    sm4_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_wr   (key_wr),
        .i_in_valid (s_in.valid),
        .o_in_ready (s_in.ready),
        .o_out_valid(m_out.valid),
        .i_out_ready(m_out.ready),
        .o_cmd      (cmd),
        .o_round    (round)
    );

    sm4_dp #(.ROUNDS(ROUNDS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_round        (round),
        .i_key          ({r_key_high, r_key_low}),
        .i_nonce        ({r_nonce_high, r_nonce_low}),
        .i_mode         (r_mode),
        .i_block_high   (s_in.data.block_high),
        .i_block_low    (s_in.data.block_low),
        .i_valid_bytes  (s_in.data.valid_bytes),
        .i_message_start(s_in.data.message_start),
        .o_out_high     (m_out.data.out_high),
        .o_out_low      (m_out.data.out_low)
    );
endmodule

FILE: rtl/sm4_ram.sv
// Generic RAM with separate read and write ports and registered read.
module sm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/sm4_ctrl.sv
// Controller: sequences key expansion, cipher rounds and result handoff.
module sm4_ctrl import sm4_pkg::*; #(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_key_wr,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_cmd                      o_cmd,
    output logic [$clog2(ROUNDS)-1:0] o_round
);
    localparam int RW = $clog2(ROUNDS);
    localparam logic [RW-1:0] LAST = RW'(ROUNDS - 1);

    t_state r_state, n_state;
    logic [RW-1:0] r_round, n_round;
    logic r_ovalid, n_ovalid;
    logic r_key_pend, n_key_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_round    <= '0;
            r_ovalid   <= 1'b0;
            r_key_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_round    <= n_round;
            r_ovalid   <= n_ovalid;
            r_key_pend <= n_key_pend;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_round    = r_round;
        n_ovalid   = r_ovalid;
        n_key_pend = r_key_pend | i_key_wr;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (r_key_pend) begin
                    o_cmd.key_load = 1'b1;
                    n_key_pend     = i_key_wr;
                    n_round        = '0;
                    n_state        = ST_EXPAND;
                end else begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.blk_load = 1'b1;
                        n_round        = '0;
                        n_state        = ST_CIPHER;
                    end
                end
            end
            ST_EXPAND: begin
                o_cmd.key_step = 1'b1;
                n_round        = r_round + 1'b1;
                if (r_round == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CIPHER: begin
                o_cmd.blk_step = 1'b1;
                n_round        = r_round + 1'b1;
                if (r_round == LAST) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for the output register to be free
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_round     = r_round;

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.blk_load |-> r_state == ST_IDLE) else $error("load outside idle");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_ovalid || i_out_ready)) else $error("result overwritten");
    a_cipher_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CIPHER && r_round == LAST) |=> r_state == ST_OUT)
        else $error("round count broken");
`endif
endmodule

FILE: rtl/sm4_dp.sv
// Datapath: round unit shared by key expansion and cipher, key store, counter.
module sm4_dp import sm4_pkg::*; #(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic [$clog2(ROUNDS)-1:0] i_round,
    input  logic [127:0]              i_key,
    input  logic [127:0]              i_nonce,
    input  logic                      i_mode,
    input  logic [63:0]               i_block_high,
    input  logic [63:0]               i_block_low,
    input  logic [4:0]                i_valid_bytes,
    input  logic                      i_message_start,
    output logic [63:0]               o_out_high,
    output logic [63:0]               o_out_low
);
    localparam int RW = $clog2(ROUNDS);

    logic [127:0] r_x;
    logic [127:0] r_data;
    logic [4:0]   r_vb;
    logic         r_ctr;
    logic [63:0]  r_counter;
    logic [63:0]  r_oh, r_ol;
    logic [31:0]  rk;
    logic [RW-1:0] raddr;
    logic [31:0]  t_in, b, lin, nw;
    logic [4:0]   vb;
    logic [63:0]  start_cnt;

    // round key for cipher round i is read ahead, so the RAM output holds it in round i
    always_comb begin
        raddr = i_round + 1'b1;
        if (i_cmd.blk_load) begin
            raddr = '0;
        end
    end

    sm4_ram #(.WIDTH(32), .DEPTH(ROUNDS)) u_rk (
        .i_clk  (i_clk),
        .i_we   (i_cmd.key_step),
        .i_waddr(i_round),
        .i_wdata(nw),
        .i_raddr(raddr),
        .o_rdata(rk)
    );

    // state word order x0..x3 from msb; each round shifts left one word
    always_comb begin
        t_in = r_x[95:64] ^ r_x[63:32] ^ r_x[31:0] ^
               (i_cmd.key_step ? ck_word(8'(i_round)) : rk);
        b    = tau(t_in);
        if (i_cmd.key_step) begin
            lin = b ^ rotl(b, 13) ^ rotl(b, 23);
        end else begin
            lin = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
        end
        nw = r_x[127:96] ^ lin;
    end

    assign start_cnt = i_message_start ? 64'd0 : r_counter;
    assign vb        = (i_valid_bytes > 5'd16) ? 5'd16 : i_valid_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else if (i_cmd.blk_load) begin
            r_counter <= (i_mode == MODE_CTR) ? start_cnt + 64'd1 : start_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            r_x <= i_key ^ FK;
        end else if (i_cmd.blk_load) begin
            r_data <= {i_block_high, i_block_low};
            r_vb   <= vb;
            r_ctr  <= i_mode;
            if (i_mode == MODE_CTR) begin
                r_x <= {i_nonce[127:64], i_nonce[63:0] + start_cnt};
            end else begin
                r_x <= {i_block_high, i_block_low};
            end
        end else if (i_cmd.key_step || i_cmd.blk_step) begin
            r_x <= {r_x[95:0], nw};
        end
        if (i_cmd.out_load) begin
            if (r_ctr == MODE_CTR) begin
                r_oh <= (r_data[127:64] ^ {r_x[31:0], r_x[63:32]}) & lead_mask(
                        (r_vb > 5'd8) ? 5'd8 : r_vb);
                r_ol <= (r_data[63:0] ^ {r_x[95:64], r_x[127:96]}) & lead_mask(
                        (r_vb > 5'd8) ? r_vb - 5'd8 : 5'd0);
            end else if (r_vb == 5'd16) begin
                r_oh <= {r_x[31:0], r_x[63:32]};
                r_ol <= {r_x[95:64], r_x[127:96]};
            end else begin
                r_oh <= '0;
                r_ol <= '0;
            end
        end
    end

    assign o_out_high = r_oh;
    assign o_out_low  = r_ol;
endmodule

FILE: tb/testbench.sv
// Testbench for the SM4 ECB/CTR unit: directed vectors, then random traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sm4_pkg::*;

    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 500000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sm4_stream_if #(.T(t_blk_in))  in_if ();
    sm4_stream_if #(.T(t_blk_out)) out_if ();

    sm4_block_cipher_ecb_ctr_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_if),
        .m_out      (out_if)
    );

    // shadow of the block's registers and state
    logic [63:0] sh_key_high, sh_key_low, sh_nonce_high, sh_nonce_low;
    logic        sh_mode;
    logic [31:0] sched_keys [32];
    logic [63:0] ctr_count;

    t_blk_out expected_blocks [$];
    int       errors;
    int       blocks_sent;
    int       blocks_checked;
    int       ctr_blocks;
    int       partial_blocks;
    int       cycle_count;
    bit       idling_on;
    int       sink_stall;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ---------------- cipher predictor ----------------
    function automatic logic [31:0] sub_word(logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] rot_left(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void build_schedule();
        logic [31:0] k [4];
        logic [31:0] ck, b;
        logic [7:0]  cb;
        k[0] = sh_key_high[63:32] ^ FK[127:96];
        k[1] = sh_key_high[31:0]  ^ FK[95:64];
        k[2] = sh_key_low[63:32]  ^ FK[63:32];
        k[3] = sh_key_low[31:0]   ^ FK[31:0];
        for (int i = 0; i < 32; i++) begin
            ck = '0;
            for (int j = 0; j < 4; j++) begin
                cb = 8'((4 * i + j) * 7);
                ck = {ck[23:0], cb};
            end
            b = sub_word(k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4] ^ ck);
            k[i % 4] = k[i % 4] ^ b ^ rot_left(b, 13) ^ rot_left(b, 23);
            sched_keys[i] = k[i % 4];
        end
    endfunction

    function automatic logic [127:0] cipher_block(logic [127:0] pt);
        logic [31:0] x [4];
        logic [31:0] b;
        x[0] = pt[127:96];
        x[1] = pt[95:64];
        x[2] = pt[63:32];
        x[3] = pt[31:0];
        for (int i = 0; i < 32; i++) begin
            b = sub_word(x[(i + 1) % 4] ^ x[(i + 2) % 4] ^ x[(i + 3) % 4] ^ sched_keys[i]);
            x[i % 4] ^= b ^ rot_left(b, 2) ^ rot_left(b, 10) ^ rot_left(b, 18)
                      ^ rot_left(b, 24);
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    function automatic logic [63:0] keep_bytes(int n);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            if (k < n) begin
                m[63 - 8 * k -: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    function automatic t_blk_out predict_block(t_blk_in it);
        t_blk_out     r;
        logic [127:0] ks;
        int           nb;
        nb = (it.valid_bytes > 16) ? 16 : int'(it.valid_bytes);
        r = '0;
        if (it.message_start) begin
            ctr_count = '0;
        end
        if (sh_mode == MODE_CTR) begin
            ks = cipher_block({sh_nonce_high, 64'(sh_nonce_low + ctr_count)});
            ctr_count = ctr_count + 64'd1;
            r.out_high = (it.block_high ^ ks[127:64]) & keep_bytes(nb);
            r.out_low  = (it.block_low ^ ks[63:0]) & keep_bytes(nb > 8 ? nb - 8 : 0);
        end else if (nb == 16) begin
            ks = cipher_block({it.block_high, it.block_low});
            r.out_high = ks[127:64];
            r.out_low  = ks[63:0];
        end
        return r;
    endfunction

    // ---------------- result checker and sink stalls ----------------
    always @(posedge i_clk) begin
        t_blk_out want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_blocks.size() == 0) begin
                $error("result with no expected block: %h %h",
                       out_if.data.out_high, out_if.data.out_low);
                errors++;
            end else begin
                want = expected_blocks.pop_front();
                blocks_checked++;
                if (out_if.data.out_high !== want.out_high) begin
                    $error("out_high: expected %h, got %h", want.out_high,
                           out_if.data.out_high);
                    errors++;
                end
                if (out_if.data.out_low !== want.out_low) begin
                    $error("out_low: expected %h, got %h", want.out_low,
                           out_if.data.out_low);
                    errors++;
                end
            end
        end
        if (sink_stall > 0) begin
            sink_stall--;
            out_if.ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            sink_stall = $urandom_range(0, 5);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ---------------- drivers ----------------
    task automatic send_block(t_blk_in it);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        expected_blocks.push_back(predict_block(it));
        blocks_sent++;
        if (sh_mode == MODE_CTR) ctr_blocks++;
        if (it.valid_bytes != 5'd16) partial_blocks++;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_KEY_HIGH:   sh_key_high   = val;
            REG_KEY_LOW:    sh_key_low    = val;
            REG_NONCE_HIGH: sh_nonce_high = val;
            REG_NONCE_LOW:  sh_nonce_low  = val;
            REG_MODE:       sh_mode       = val[0];
            default: ;
        endcase
        if (idx == REG_KEY_HIGH || idx == REG_KEY_LOW) begin
            build_schedule();
            // let the key expansion finish before anything else is written
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic load_setup(logic [63:0] kh, logic [63:0] kl, logic [63:0] nh,
                              logic [63:0] nl, logic md);
        write_reg(REG_KEY_HIGH, kh);
        write_reg(REG_KEY_LOW, kl);
        write_reg(REG_NONCE_HIGH, nh);
        write_reg(REG_NONCE_LOW, nl);
        write_reg(REG_MODE, {63'd0, md});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_blk_in make_block(logic [4:0] nb, logic st);
        t_blk_in it;
        it.block_high    = rand64();
        it.block_low     = rand64();
        it.valid_bytes   = nb;
        it.message_start = st;
        return it;
    endfunction

    // ---------------- tests ----------------
    task automatic test_ecb_directed();
        load_setup(64'h0123456789abcdef, 64'hfedcba9876543210, '0, '0, MODE_ECB);
        // standard vector, then extremes and partial blocks (all zero in ECB)
        send_block('{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16, 1'b0});
        send_block('{64'h0, 64'h0, 5'd16, 1'b0});
        send_block('{'1, '1, 5'd16, 1'b1});
        send_block('{'1, '1, 5'd15, 1'b0});
        send_block('{'1, '1, 5'd1, 1'b0});
        send_block('{'1, '1, 5'd0, 1'b0});
        send_block('{'1, '1, 5'd17, 1'b0});
        send_block('{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd31, 1'b0});
        drain_results();
    endtask

    task automatic test_ctr_directed();
        load_setup('1, '0, 64'h0011223344556677, 64'hfffffffffffffffe, MODE_CTR);
        // counter wraps past the top of the low nonce half
        send_block(make_block(5'd16, 1'b1));
        send_block(make_block(5'd16, 1'b0));
        send_block(make_block(5'd16, 1'b0));
        send_block(make_block(5'd8, 1'b0));
        send_block(make_block(5'd9, 1'b0));
        send_block(make_block(5'd1, 1'b0));
        send_block(make_block(5'd0, 1'b0));
        send_block(make_block(5'd15, 1'b1));
        send_block(make_block(5'd24, 1'b0));
        send_block('{'1, '1, 5'd16, 1'b0});
        send_block('{'0, '0, 5'd16, 1'b1});
        drain_results();
    endtask

    task automatic test_random_phases();
        logic [4:0] nb;
        for (int ph = 0; ph < 10; ph++) begin
            idling_on = (ph < 8);
            case (ph)
                0: load_setup('0, '0, '0, '0, MODE_CTR);
                1: load_setup('1, '1, '1, '1, MODE_ECB);
                2: load_setup(rand64(), rand64(), '1, 64'hffffffffffffffc0, MODE_CTR);
                default: load_setup(rand64(), rand64(), rand64(), rand64(),
                                    logic'($urandom_range(0, 1)));
            endcase
            for (int n = 0; n < 108; n++) begin
                nb = ($urandom_range(0, 9) < 6) ? 5'd16 : 5'($urandom_range(0, 31));
                send_block(make_block(nb, $urandom_range(0, 11) == 0));
                // sender holds off until the unit has emptied
                if (ph == 4 && n == 50) drain_results();
            end
            drain_results();
        end
    endtask

    initial begin
        errors         = 0;
        blocks_sent    = 0;
        blocks_checked = 0;
        ctr_blocks     = 0;
        partial_blocks = 0;
        cycle_count    = 0;
        sink_stall     = 0;
        idling_on      = 1'b1;
        ctr_count      = '0;
        sh_key_high    = '0;
        sh_key_low     = '0;
        sh_nonce_high  = '0;
        sh_nonce_low   = '0;
        sh_mode        = MODE_ECB;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        out_if.ready   = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_ecb_directed();
        test_ctr_directed();
        test_random_phases();
        $display("covered %0d blocks (%0d counter mode, %0d partial), %0d results checked",
                 blocks_sent, ctr_blocks, partial_blocks, blocks_checked);
        $display("key, nonce and mode settings varied, extremes and counter wrap included");
        if (errors == 0 && expected_blocks.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
